### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent at one edge implies consequent at the next.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/l2s_pkg.sv
package l2s_pkg;

  localparam int NCELL = 4;

  // single precision bit patterns
  localparam logic [31:0] COEF_3    = 32'h3D75686E;  //  0.059914046
  localparam logic [31:0] COEF_2    = 32'hBDDF041C;  // -0.10889456
  localparam logic [31:0] COEF_1    = 32'h3DDD1C1A;  //  0.107963754
  localparam logic [31:0] COEF_0    = 32'h3C943665;  //  0.018092343
  localparam logic [31:0] SLOPE     = 32'h414EB852;  //  12.92
  localparam logic [31:0] OFFSET    = 32'hBD6147AE;  // -0.055
  localparam logic [30:0] KNEE      = 31'h3B4D2E1C;  //  0.0031308
  localparam logic [31:0] VA_SET    = 32'h3E800000;
  localparam logic [31:0] VA_MASK   = 32'h3EFFFFFF;
  localparam logic [31:0] FACT_BASE = 32'h40000000;
  localparam logic [7:0]  IDX_BIAS  = 8'd118;

  localparam logic [7:0] TAB_HI [16] = '{
    8'h00, 8'h0a, 8'h19, 8'h26, 8'h32, 8'h41, 8'h4d, 8'h5c,
    8'h68, 8'h75, 8'h83, 8'h8f, 8'ha0, 8'haa, 8'hb9, 8'hc6
  };
  localparam logic [7:0] TAB_LO [16] = '{
    8'h00, 8'hb7, 8'h04, 8'h0d, 8'hcb, 8'he7, 8'h41, 8'h68,
    8'h51, 8'hd1, 8'heb, 8'hf2, 8'h00, 8'hb7, 8'h04, 8'h0d
  };

  // item context that travels beside the arithmetic
  typedef struct packed {
    logic [30:0] mag;
    logic        sign;
    logic        last;
  } side_t;

  // mantissa forced into [0.25,0.5)
  function automatic logic [31:0] va_bits(input logic [30:0] mag);
    return (VA_SET | {1'b0, mag}) & VA_MASK;
  endfunction

  // scale factor; only the low four index bits select an entry, a negative index gives zero
  function automatic logic [31:0] factor_bits(input logic [30:0] mag);
    logic [7:0] idx;
    logic [7:0] hi;
    logic [7:0] lo;
    idx = mag[30:23] - IDX_BIAS;
    hi  = idx[7] ? 8'd0 : TAB_HI[idx[3:0]];
    lo  = idx[7] ? 8'd0 : TAB_LO[idx[3:0]];
    return FACT_BASE | {6'd0, hi, 18'd0} | {14'd0, lo, 10'd0};
  endfunction

  // addend of polynomial cell k
  function automatic logic [31:0] poly_coef(input logic [1:0] k);
    logic [31:0] c;
    unique case (k)
      2'd0:    c = COEF_2;
      2'd1:    c = COEF_1;
      default: c = COEF_0;
    endcase
    return c;
  endfunction

endpackage

### rtl/linear_to_srgb_encode.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------
// input    | valid_i / stall_o  | sample_in_i[31:0], is_last_in_i
// output   | valid_o / stall_i  | sample_out_o[31:0], is_last_out_o
//
// One request per cycle sustained while stall_i is low; the pipeline is the row of
// four fused multiply-add cells of three register stages each.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled result holds in the last stage while empty stages upstream keep
// filling; stall_o rises only once every stage holds a request.
`include "assert_macros.svh"

module linear_to_srgb_encode
  import l2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] sample_in_i,
  input  logic        is_last_in_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] sample_out_o,
  output logic        is_last_out_o
);

  // Cells 0..2 run the cubic in va (Horner form, one fused step each).
  // Cell 3 is either poly*factor - 0.055 or, at or below the knee,
  // the linear segment mag*12.92 (a fused step with a zero addend).
  logic        c_vin   [NCELL];
  logic        c_itake [NCELL];
  logic        c_vout  [NCELL];
  logic        c_otake [NCELL];
  logic [31:0] c_a     [NCELL];
  logic [31:0] c_b     [NCELL];
  logic [31:0] c_c     [NCELL];
  logic [31:0] c_res   [NCELL];
  side_t       c_sin   [NCELL];
  side_t       c_sout  [NCELL];
  logic        lin_seg;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign c_vin[g] = valid_i;
      assign c_sin[g] = '{mag: sample_in_i[30:0], sign: sample_in_i[31], last: is_last_in_i};
      assign c_a[g]   = COEF_3;
    end else begin : g_link
      assign c_vin[g] = c_vout[g-1];
      assign c_sin[g] = c_sout[g-1];
    end

    if (g == NCELL - 1) begin : g_tail
      // ordered compare on a magnitude: NaN patterns land above the knee
      assign lin_seg    = c_sin[g].mag <= KNEE;
      assign c_a[g]     = lin_seg ? {1'b0, c_sin[g].mag} : c_res[g-1];
      assign c_b[g]     = lin_seg ? SLOPE : factor_bits(c_sin[g].mag);
      assign c_c[g]     = lin_seg ? 32'd0 : OFFSET;
      assign c_otake[g] = !stall_i;
    end else begin : g_poly
      if (g != 0) begin : g_acc
        assign c_a[g] = c_res[g-1];
      end
      assign c_b[g]     = va_bits(c_sin[g].mag);
      assign c_c[g]     = poly_coef(2'(g));
      assign c_otake[g] = c_itake[g+1];
    end

    l2s_fma_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_vin[g]),
      .in_take_o   (c_itake[g]),
      .a_i         (c_a[g]),
      .b_i         (c_b[g]),
      .c_i         (c_c[g]),
      .side_i      (c_sin[g]),
      .out_valid_o (c_vout[g]),
      .out_take_i  (c_otake[g]),
      .res_o       (c_res[g]),
      .side_o      (c_sout[g])
    );
  end

  assign stall_o       = !c_itake[0];
  assign valid_o       = c_vout[NCELL-1];
  // sign of the input is ORed back over the encoded magnitude
  assign sample_out_o  = {c_res[NCELL-1][31] | c_sout[NCELL-1].sign, c_res[NCELL-1][30:0]};
  assign is_last_out_o = c_sout[NCELL-1].last;

  `ASSERT_CLK(a_first_neg, clk_i, rst_ni, !c_vout[0] || c_res[0][31], "first Horner step must be negative")
  `ASSERT_CLK(a_poly_pos, clk_i, rst_ni, !c_vout[2] || (!c_res[2][31] && c_res[2][30:23] != 8'hFF), "cubic out of range")
  `ASSERT_CLK(a_out_finite, clk_i, rst_ni, !valid_o || sample_out_o[30:23] != 8'hFF, "encoded sample not finite")

endmodule

### rtl/l2s_fma_cell.sv
`include "assert_macros.svh"

// One fused multiply-add a*b+c, round to nearest even, subnormals kept.
// Three stages: multiply, align and add, normalize and round.
module l2s_fma_cell
  import l2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_take_o,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  side_t       side_i,
  output logic        out_valid_o,
  input  logic        out_take_i,
  output logic [31:0] res_o,
  output side_t       side_o
);

  logic [2:0] v_q;
  logic [2:0] take;

  assign take[2]   = !v_q[2] || out_take_i;
  assign take[1]   = !v_q[1] || take[2];
  assign take[0]   = !v_q[0] || take[1];
  assign in_take_o = take[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) v_q[0] <= in_valid_i;
      if (take[1]) v_q[1] <= v_q[0];
      if (take[2]) v_q[2] <= v_q[1];
    end
  end

  // ---------------- stage A: product
  logic [7:0]  a_exp, b_exp;
  logic [23:0] a_man, b_man;
  logic [47:0] prod_d, prod_q;
  logic [8:0]  eab_d, eab_q;
  logic        sp_q;
  logic [31:0] c_q;
  side_t       side_a_q;

  assign a_exp  = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign b_exp  = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  assign a_man  = {|a_i[30:23], a_i[22:0]};
  assign b_man  = {|b_i[30:23], b_i[22:0]};
  assign prod_d = a_man * b_man;
  assign eab_d  = {1'b0, a_exp} + {1'b0, b_exp};

  always_ff @(posedge clk_i) begin
    if (take[0] && in_valid_i) begin
      prod_q   <= prod_d;
      eab_q    <= eab_d;
      sp_q     <= a_i[31] ^ b_i[31];
      c_q      <= c_i;
      side_a_q <= side_i;
    end
  end

  // ---------------- stage B: align and add
  // product sits at bits 50:3, addend starts at bits 76:53 and shifts right
  logic [7:0]         c_exp;
  logic [23:0]        c_man;
  logic signed [10:0] shift_amt;
  logic [6:0]         sh_y;
  logic [76:0]        x_full, y_full, x_al, y_al;
  logic signed [10:0] fe_d, fe_q;
  logic [77:0]        sum_xy, dif_xy, dif_yx, r_d, r_q;
  logic               rs_d, rs_q;
  side_t              side_b_q;

  assign c_exp     = (c_q[30:23] == 8'd0) ? 8'd1 : c_q[30:23];
  assign c_man     = {|c_q[30:23], c_q[22:0]};
  assign shift_amt = $signed({2'b00, eab_q}) - 11'sd100 - $signed({3'b000, c_exp});
  assign sh_y      = shift_amt[6:0];
  assign x_full    = {26'd0, prod_q, 3'd0};
  assign y_full    = {c_man, 53'd0};

  always_comb begin
    x_al = x_full;
    y_al = y_full;
    fe_d = $signed({2'b00, eab_q}) - 11'sd303;
    if (shift_amt < 11'sd0) begin
      // product far below the addend: only its sticky remains
      x_al = {76'd0, |prod_q};
      fe_d = $signed({3'b000, c_exp}) - 11'sd203;
    end else if (shift_amt > 11'sd76) begin
      y_al = {76'd0, |c_man};
    end else begin
      y_al = (y_full >> sh_y) | {76'd0, |(y_full & ~({77{1'b1}} << sh_y))};
    end
  end

  assign sum_xy = {1'b0, x_al} + {1'b0, y_al};
  assign dif_xy = {1'b0, x_al} - {1'b0, y_al};
  assign dif_yx = {1'b0, y_al} - {1'b0, x_al};

  always_comb begin
    r_d  = sum_xy;
    rs_d = sp_q;
    if (sp_q != c_q[31]) begin
      if (dif_xy[77]) begin
        r_d  = dif_yx;
        rs_d = c_q[31];
      end else begin
        r_d  = dif_xy;
      end
    end
    if (r_d == 78'd0) rs_d = sp_q & c_q[31];
  end

  always_ff @(posedge clk_i) begin
    if (take[1] && v_q[0]) begin
      r_q      <= r_d;
      rs_q     <= rs_d;
      fe_q     <= fe_d;
      side_b_q <= side_a_q;
    end
  end

  // ---------------- stage C: normalize and round
  function automatic logic [6:0] lead_pos(input logic [77:0] v);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 78; i++) begin
      if (v[i]) p = 7'(i);
    end
    return p;
  endfunction

  logic [6:0]         lpos;
  logic signed [11:0] ebr, q_pos, shc;
  logic               is_norm;
  logic [103:0]       win, xs;
  logic               st;
  logic [6:0]         sh_w;
  logic [23:0]        mant;
  logic               rnd;
  logic [7:0]         exp_f;
  logic [30:0]        rounded;
  logic [31:0]        res_d, res_q;
  side_t              side_c_q;

  assign lpos    = lead_pos(r_q);
  assign ebr     = $signed({5'd0, lpos}) + $signed({fe_q[10], fe_q}) + 12'sd127;
  assign is_norm = ebr > 12'sd0;
  assign q_pos   = is_norm ? ($signed({5'd0, lpos}) - 12'sd23)
                           : (-12'sd149 - $signed({fe_q[10], fe_q}));
  assign shc     = q_pos + 12'sd24;
  assign sh_w    = shc[6:0];
  assign win     = {r_q, 26'd0};

  always_comb begin
    if (shc > 12'sd103) begin
      xs = '0;
      st = |r_q;
    end else begin
      xs = win >> sh_w;
      st = |(win & ~({104{1'b1}} << sh_w));
    end
  end

  assign mant    = xs[25:2];
  assign rnd     = xs[1] && (xs[0] || st || mant[0]);
  assign exp_f   = is_norm ? ebr[7:0] : 8'd0;
  assign rounded = {exp_f, mant[22:0]} + {30'd0, rnd};

  always_comb begin
    if (r_q == 78'd0) begin
      res_d = {rs_q, 31'd0};
    end else if (ebr > 12'sd254) begin
      res_d = {rs_q, 8'hFF, 23'd0};
    end else begin
      res_d = {rs_q, rounded};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[2] && v_q[1]) begin
      res_q    <= res_d;
      side_c_q <= side_b_q;
    end
  end

  assign out_valid_o = v_q[2];
  assign res_o       = res_q;
  assign side_o      = side_c_q;

  `ASSERT_NEXT(a_stage_a_hold, clk_i, rst_ni, v_q[0] && !take[1], v_q[0] && $stable(prod_q), "stage A lost its product")
  `ASSERT_CLK(a_norm_lead, clk_i, rst_ni, !(v_q[1] && r_q != 78'd0 && is_norm && ebr < 12'sd255) || mant[23], "normal result without leading one")
  `ASSERT_CLK(a_subn_lead, clk_i, rst_ni, !(v_q[1] && r_q != 78'd0 && !is_norm) || !mant[23], "subnormal result with leading one")

endmodule
